[hdl/rde_pkg.sv]
`default_nettype none

package rde_pkg;

    // operation codes of an input item
    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_LOAD    = 3'd1;
    localparam logic [2:0] OP_REVERSE = 3'd2;
    localparam logic [2:0] OP_DELETE  = 3'd3;
    localparam logic [2:0] OP_FINISH  = 3'd4;

    localparam int ValueWidth = 32;

    typedef enum logic [2:0] {
        CMD_START,
        CMD_LOAD,
        CMD_REVERSE,
        CMD_DELETE,
        CMD_FINISH
    } cmd_kind_t;

    typedef struct packed {
        logic [2:0]                   operation;
        logic signed [ValueWidth-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [ValueWidth-1:0] element;
        logic                         is_error;
        logic                         is_empty;
        logic                         last;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t                    kind;
        logic signed [ValueWidth-1:0] value;
    } cmd_t;

endpackage

`default_nettype wire

[hdl/rde_ram.sv]
`default_nettype none

module rde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] storage_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            storage_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= storage_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/rde_front.sv]
`default_nettype none

module rde_front
    import rde_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    output logic          cmd_valid,
    input  wire logic     cmd_ready,
    output cmd_t          cmd
);

    // two-entry command queue toward the back end
    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    cmd_kind_t  kind;
    logic       known_op;
    logic       store;
    logic       take;

    // decode the operation; unknown codes are swallowed here
    always_comb
    begin
        known_op = 1'b1;
        kind     = CMD_START;
        unique case (item.operation)
            OP_START:   kind = CMD_START;
            OP_LOAD:    kind = CMD_LOAD;
            OP_REVERSE: kind = CMD_REVERSE;
            OP_DELETE:  kind = CMD_DELETE;
            OP_FINISH:  kind = CMD_FINISH;
            default:    known_op = 1'b0;
        endcase
    end

    assign full      = (count_reg == 2'd2);
    assign store     = push && !full && known_op;
    assign cmd_valid = (count_reg != 2'd0);
    assign take      = cmd_valid && cmd_ready;
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = store ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (store && !take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (take && !store)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            entry_reg[wr_ptr_reg] <= '{kind: kind, value: item.value};
        end
    end

endmodule

`default_nettype wire

[hdl/rde_back.sv]
`default_nettype none

module rde_back
    import rde_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cmd_valid,
    output logic       cmd_ready,
    input  wire cmd_t  cmd,
    output logic       empty,
    input  wire logic  pop,
    output out_item_t  result
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FullCount = CW'(DEPTH);
    localparam logic [IW-1:0] LastSlot  = IW'(DEPTH - 1);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [IW-1:0]   front_reg, front_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            reversed_reg, reversed_next;
    logic            error_reg, error_next;
    logic [IW-1:0]   ptr_reg, ptr_next;
    logic [CW-1:0]   left_reg, left_next;
    logic            pend_reg, pend_next;
    logic            pend_last_reg, pend_last_next;

    // result queue
    out_item_t       ofifo_reg [4];
    logic [1:0]      owr_reg, owr_next;
    logic [1:0]      ord_reg, ord_next;
    logic [2:0]      ocnt_reg, ocnt_next;
    logic            owr_en;
    out_item_t       owr_data;
    logic            opop;

    logic            take;
    logic            rd_en;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    logic [ValueWidth-1:0] rd_data;

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [IW+1:0] s;
        s = (IW+2)'(a) + (IW+2)'(b);
        if (s >= (IW+2)'(DEPTH))
        begin
            s = s - (IW+2)'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

    assign empty  = (ocnt_reg == 3'd0);
    assign opop   = pop && !empty;
    assign result = ofifo_reg[ord_reg];

    assign cmd_ready = (state_reg == ST_IDLE) && !pend_reg &&
                       ((cmd.kind != CMD_FINISH) || (ocnt_reg != 3'd4));
    assign take      = cmd_valid && cmd_ready;
    assign rd_en     = (state_reg == ST_EMIT) &&
                       (({1'b0, ocnt_reg} + {3'b000, pend_reg}) < 4'd4);
    assign wr_addr   = wrap_add(front_reg, count_reg);

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        reversed_next  = reversed_reg;
        error_next     = error_reg;
        ptr_next       = ptr_reg;
        left_next      = left_reg;
        pend_next      = rd_en;
        pend_last_next = (left_reg == CW'(1));
        wr_en          = 1'b0;
        owr_en         = pend_reg;
        owr_data       = '{element: rd_data, is_error: 1'b0, is_empty: 1'b0,
                           last: pend_last_reg};

        if (rd_en)
        begin
            left_next = left_reg - CW'(1);
            if (reversed_reg)
            begin
                ptr_next = (ptr_reg == '0) ? LastSlot : ptr_reg - IW'(1);
            end
            else
            begin
                ptr_next = wrap_add(ptr_reg, CW'(1));
            end
            if (left_reg == CW'(1))
            begin
                state_next = ST_IDLE;
            end
        end

        if (take)
        begin
            unique case (cmd.kind)
                CMD_START:
                begin
                    front_next    = '0;
                    count_next    = '0;
                    reversed_next = 1'b0;
                    error_next    = 1'b0;
                end
                CMD_LOAD:
                begin
                    if (!error_reg)
                    begin
                        if (count_reg == FullCount)
                        begin
                            error_next = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
                CMD_REVERSE:
                begin
                    if (!error_reg)
                    begin
                        reversed_next = !reversed_reg;
                    end
                end
                CMD_DELETE:
                begin
                    if (!error_reg)
                    begin
                        if (count_reg == '0)
                        begin
                            error_next = 1'b1;
                        end
                        else
                        begin
                            if (!reversed_reg)
                            begin
                                front_next = wrap_add(front_reg, CW'(1));
                            end
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
                CMD_FINISH:
                begin
                    if (error_reg || (count_reg == '0))
                    begin
                        owr_en   = 1'b1;
                        owr_data = '{element: '0, is_error: error_reg,
                                     is_empty: !error_reg, last: 1'b1};
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                        left_next  = count_reg;
                        ptr_next   = reversed_reg ?
                                     wrap_add(front_reg, count_reg - CW'(1)) :
                                     front_reg;
                    end
                end
                default:
                begin
                    error_next = error_reg;
                end
            endcase
        end

        owr_next = owr_en ? owr_reg + 2'd1 : owr_reg;
        ord_next = opop ? ord_reg + 2'd1 : ord_reg;
        ocnt_next = ocnt_reg;
        if (owr_en && !opop)
        begin
            ocnt_next = ocnt_reg + 3'd1;
        end
        else if (opop && !owr_en)
        begin
            ocnt_next = ocnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            reversed_reg  <= 1'b0;
            error_reg     <= 1'b0;
            ptr_reg       <= '0;
            left_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            owr_reg       <= '0;
            ord_reg       <= '0;
            ocnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            reversed_reg  <= reversed_next;
            error_reg     <= error_next;
            ptr_reg       <= ptr_next;
            left_reg      <= left_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            owr_reg       <= owr_next;
            ord_reg       <= ord_next;
            ocnt_reg      <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (owr_en)
        begin
            ofifo_reg[owr_reg] <= owr_data;
        end
    end

    rde_ram #(
        .WIDTH (ValueWidth),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd.value),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FullCount)
        else $error("element count above depth");

    a_emit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (!error_reg && left_reg != '0 &&
                                    left_reg <= count_reg))
        else $error("emit run with bad bookkeeping");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        owr_en |-> (ocnt_reg != 3'd4))
        else $error("result queue overflow");

    a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> pend_reg)
        else $error("issued read lost");

    a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !take)
        else $error("command taken while read data lands");
`endif

endmodule

`default_nettype wire

[hdl/reversible_deque_engine.sv]
// start, load, reverse and delete take effect when the back end takes them from
// the front-end queue; a finish writes its result directly for an error or empty
// run, else each result follows a store read, one per cycle while pop keeps up
// throughput: 1 item per cycle while full is low; a finish holds the back end
// while its elements pass the single registered read port of the element store
// reset: rst_n is asynchronous, active low; clears the deque, flags and both queues
`default_nettype none

module reversible_deque_engine
    import rde_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    // command side: a transfer happens when push is high and full is low
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    // result side: a transfer happens when pop is high and empty is low
    output logic          empty,
    input  wire logic     pop,
    output out_item_t     result
);

    // decoded commands passing from the front end to the back end
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // front end: decodes operation codes, drops unknown ones and buffers
    // up to two commands so input transfers continue while a finish runs, until full is set
    rde_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // back end: ring-buffer bookkeeping with a lazy reverse flag, the
    // element store, the emit sequencer and a four-entry result queue
    rde_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    import rde_pkg::*;

    localparam int DEPTH = 64;
    // operation codes the block must ignore
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;
    localparam int ITEM_TARGET = 320;
    localparam int IDLE_PCT    = 15;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_CYCLES = 20;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  item = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t result;

    reversible_deque_engine #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // commands still to be offered, filled at time zero
    in_item_t  cmd_backlog[$];
    // results the deque should emit, oldest first
    out_item_t due_results[$];

    // shadow copy of the deque
    logic signed [31:0] shadow_store [DEPTH];
    logic [5:0]         shadow_head = '0;
    logic [6:0]         shadow_count = '0;
    bit                 shadow_rev;
    bit                 shadow_err;

    int items_in    = 0;
    int results_out = 0;
    int fault_count = 0;
    int finishes    = 0;
    int error_runs  = 0;
    int empty_runs  = 0;
    int overflows   = 0;
    int underflows  = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // generous fixed limit; a correct run needs a small fraction of this
    initial
    begin
        #(2_000_000);
        $display("Verification failed");
        $finish;
    end

    // update the shadow deque with one accepted command and queue what it emits
    task automatic track_deque(input in_item_t cmd);
        out_item_t  r;
        logic [6:0] off;
        logic [5:0] slot;
        r = '0;
        case (cmd.operation)
            OP_START:
            begin
                shadow_head  = '0;
                shadow_count = '0;
                shadow_rev   = 1'b0;
                shadow_err   = 1'b0;
            end
            OP_LOAD:
            begin
                if (!shadow_err)
                begin
                    if (shadow_count >= DEPTH)
                    begin
                        shadow_err = 1'b1;
                        overflows++;
                    end
                    else
                    begin
                        // always the physical back, whatever the direction
                        slot = shadow_head + shadow_count[5:0];
                        shadow_store[slot] = cmd.value;
                        shadow_count++;
                    end
                end
            end
            OP_REVERSE:
            begin
                if (!shadow_err)
                    shadow_rev = !shadow_rev;
            end
            OP_DELETE:
            begin
                if (!shadow_err)
                begin
                    if (shadow_count == 0)
                    begin
                        shadow_err = 1'b1;
                        underflows++;
                    end
                    else
                    begin
                        // reversed: logical front is the physical back, head stays
                        if (!shadow_rev)
                            shadow_head = shadow_head + 6'd1;
                        shadow_count--;
                    end
                end
            end
            OP_FINISH:
            begin
                finishes++;
                if (shadow_err)
                begin
                    r.is_error = 1'b1;
                    r.last     = 1'b1;
                    due_results.push_back(r);
                    error_runs++;
                end
                else if (shadow_count == 0)
                begin
                    r.is_empty = 1'b1;
                    r.last     = 1'b1;
                    due_results.push_back(r);
                    empty_runs++;
                end
                else
                begin
                    for (int k = 0; k < shadow_count; k++)
                    begin
                        off = shadow_rev ? (shadow_count - 7'd1 - 7'(k)) : 7'(k);
                        slot = shadow_head + off[5:0];
                        r.element = shadow_store[slot];
                        r.last    = (k + 1 == shadow_count);
                        due_results.push_back(r);
                    end
                end
            end
            default:
            begin
                // spare codes do nothing
            end
        endcase
    endtask

    task automatic add_cmd(input logic [2:0] op, input logic [31:0] val);
        in_item_t it;
        it.operation = op;
        it.value     = val;
        cmd_backlog.push_back(it);
    endtask

    // mostly random words, now and then one of the extremes
    function automatic logic [31:0] rand_value();
        logic [31:0] corner [4];
        corner[0] = 32'h8000_0000;
        corner[1] = 32'h7fff_ffff;
        corner[2] = 32'h0000_0000;
        corner[3] = 32'hffff_ffff;
        if ($urandom_range(0, 9) == 0)
            return corner[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    // sender: offers the backlog head, withdraws now and then
    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        bit offer;
        bit steady;
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                track_deque(cmd_backlog.pop_front());
                items_in <= items_in + 1;
            end
            // a stretch with no gaps on the sender
            steady = (items_in >= 200) && (items_in < 260);
            offer = (cmd_backlog.size() != 0) &&
                    (steady || $urandom_range(0, 99) >= IDLE_PCT);
            push <= offer;
            if (offer)
                item <= cmd_backlog[0];
        end
    end

    // long receiver hold-off once the run is under way, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && items_in >= 80)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver: takes results and checks each against the oldest expected one
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        out_item_t want;
        bit steady;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                results_out <= results_out + 1;
                if (due_results.size() == 0)
                begin
                    $error("unexpected result: element %0d error %0b empty %0b last %0b",
                           result.element, result.is_error, result.is_empty, result.last);
                    fault_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result.element !== want.element)
                    begin
                        $error("element: expected %0d, got %0d", want.element, result.element);
                        fault_count++;
                    end
                    if (result.is_error !== want.is_error)
                    begin
                        $error("is_error: expected %0b, got %0b", want.is_error,
                               result.is_error);
                        fault_count++;
                    end
                    if (result.is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0b, got %0b", want.is_empty,
                               result.is_empty);
                        fault_count++;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, result.last);
                        fault_count++;
                    end
                end
            end
            // a stretch with no gaps on the receiver
            steady = (results_out >= 40) && (results_out < 160);
            if (hold_left != 0)
                pop <= 1'b0;
            else if (steady)
                pop <= 1'b1;
            else
                pop <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // stimulus, then the drain and the verdict
    initial
    begin : stimulus_and_close
        int n;
        int m;
        int pick;

        // directed: empty finish, extremes, reverse, delete both ways
        add_cmd(OP_START, $urandom);
        add_cmd(OP_FINISH, $urandom);
        add_cmd(OP_LOAD, 32'h8000_0000);
        add_cmd(OP_LOAD, 32'h7fff_ffff);
        add_cmd(OP_LOAD, 32'h0000_0000);
        add_cmd(OP_LOAD, 32'hffff_ffff);
        add_cmd(OP_FINISH, $urandom);
        add_cmd(OP_REVERSE, $urandom);
        add_cmd(OP_FINISH, $urandom);
        // load while reversed lands on the logical front
        add_cmd(OP_LOAD, 32'h5a5a_5a5a);
        add_cmd(OP_DELETE, $urandom);
        add_cmd(OP_DELETE, $urandom);
        add_cmd(OP_FINISH, $urandom);
        // finish leaves the state alone, so it emits again
        add_cmd(OP_FINISH, $urandom);
        add_cmd(OP_REVERSE, $urandom);
        add_cmd(OP_DELETE, $urandom);
        add_cmd(OP_DELETE, $urandom);
        // this delete takes the last element, so the deque is empty again
        add_cmd(OP_DELETE, $urandom);
        add_cmd(OP_LOAD, 32'h1234_5678);
        add_cmd(OP_REVERSE, $urandom);
        add_cmd(OP_FINISH, $urandom);
        add_cmd(OP_FINISH, $urandom);
        add_cmd(OP_SPARE_LO, $urandom);
        add_cmd(OP_SPARE_MID, $urandom);
        add_cmd(OP_SPARE_HI, $urandom);

        // random cases: usually a start, a run of loads, mixed commands, finish
        while (cmd_backlog.size() < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) != 0)
                add_cmd(OP_START, $urandom);
            // now and then fill to the brim or overflow
            pick = $urandom_range(0, 7);
            n = (pick == 0) ? $urandom_range(DEPTH - 2, DEPTH + 2) : $urandom_range(0, 10);
            for (int k = 0; k < n; k++)
                add_cmd(OP_LOAD, rand_value());
            m = $urandom_range(0, 16);
            for (int k = 0; k < m; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    add_cmd(OP_LOAD, rand_value());
                else if (pick < 60)
                    add_cmd(OP_REVERSE, $urandom);
                else if (pick < 95)
                    add_cmd(OP_DELETE, $urandom);
                else
                    add_cmd(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom);
            end
            add_cmd(OP_FINISH, $urandom);
            if ($urandom_range(0, 3) == 0)
                add_cmd(OP_FINISH, $urandom);
        end

        @(posedge rst_n);
        while (cmd_backlog.size() != 0)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d commands and %0d results over %0d finishes",
                 items_in, results_out, finishes);
        $display("error runs %0d, empty runs %0d, overflows %0d, underflows %0d",
                 error_runs, empty_runs, overflows, underflows);
        if (fault_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/rde_pkg.sv
hdl/rde_ram.sv
hdl/rde_front.sv
hdl/rde_back.sv
hdl/reversible_deque_engine.sv
bench/testbench.sv
